[hw/rtl/wsfd_pkg.sv]
package wsfd_pkg;

  localparam int unsigned LEN_W = 29;

  typedef logic [1:0] kind_t;

  localparam kind_t KIND_START   = 2'd0;
  localparam kind_t KIND_PAYLOAD = 2'd1;
  localparam kind_t KIND_ERROR   = 2'd2;

  localparam logic ERR_UNSUPPORTED = 1'b0;
  localparam logic ERR_TOO_LARGE   = 1'b1;

  localparam logic [6:0] LEN_CODE_16 = 7'd126;
  localparam logic [6:0] LEN_CODE_64 = 7'd127;

  localparam logic [3:0] EXT_BYTES_16 = 4'd2;
  localparam logic [3:0] EXT_BYTES_64 = 4'd8;

  localparam logic [LEN_W-1:0] LIMIT_RESET = 29'd268435456;

  typedef struct packed {
    kind_t            kind;
    logic [3:0]       opcode;
    logic [LEN_W-1:0] len;
    logic [7:0]       data;
    logic             last;
    logic             err;
  } result_t;

endpackage

[hw/rtl/wsfd_parser.sv]
module wsfd_parser (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         step,
  input  logic [7:0]                   byte_in,
  input  logic                         cfg_we,
  input  logic [wsfd_pkg::LEN_W-1:0]   cfg_data,
  output logic                         res_valid,
  output wsfd_pkg::result_t            res
);

  localparam logic [1:0] PH_HDR0 = 2'd0;
  localparam logic [1:0] PH_HDR1 = 2'd1;
  localparam logic [1:0] PH_EXT  = 2'd2;
  localparam logic [1:0] PH_BODY = 2'd3;

  logic [1:0]                  phase, phase_next;
  logic [3:0]                  held_opcode, held_opcode_next;
  logic [7:0]                  held_first, held_first_next;
  logic [wsfd_pkg::LEN_W-1:0]  acc, acc_next;
  logic                        acc_ovf, acc_ovf_next;
  logic [3:0]                  ext_left, ext_left_next;
  logic [wsfd_pkg::LEN_W-1:0]  body_left, body_left_next;
  logic [wsfd_pkg::LEN_W-1:0]  max_len;

  logic                        fin;
  logic                        fin_big;
  logic [wsfd_pkg::LEN_W-1:0]  fin_len;

  always_comb begin
    phase_next       = phase;
    held_opcode_next = held_opcode;
    held_first_next  = held_first;
    acc_next         = acc;
    acc_ovf_next     = acc_ovf;
    ext_left_next    = ext_left;
    body_left_next   = body_left;
    fin              = 1'b0;
    fin_big          = 1'b0;
    fin_len          = '0;
    res_valid        = 1'b0;
    res.kind         = wsfd_pkg::KIND_START;
    res.opcode       = held_opcode;
    res.len          = '0;
    res.data         = 8'd0;
    res.last         = 1'b0;
    res.err          = 1'b0;

    if (step) begin
      case (phase)
        PH_HDR0: begin
          held_first_next  = byte_in;
          held_opcode_next = byte_in[3:0];
          phase_next       = PH_HDR1;
        end
        PH_HDR1: begin
          if (!held_first[7] || byte_in[7]) begin
            phase_next = PH_HDR0;
            res_valid  = 1'b1;
            res.kind   = wsfd_pkg::KIND_ERROR;
            res.last   = 1'b1;
            res.err    = wsfd_pkg::ERR_UNSUPPORTED;
          end else if (byte_in[6:0] == wsfd_pkg::LEN_CODE_16 ||
                       byte_in[6:0] == wsfd_pkg::LEN_CODE_64) begin
            acc_next      = '0;
            acc_ovf_next  = 1'b0;
            ext_left_next = (byte_in[6:0] == wsfd_pkg::LEN_CODE_16) ?
                            wsfd_pkg::EXT_BYTES_16 : wsfd_pkg::EXT_BYTES_64;
            phase_next    = PH_EXT;
          end else begin
            fin     = 1'b1;
            fin_len = {{(wsfd_pkg::LEN_W-7){1'b0}}, byte_in[6:0]};
          end
        end
        PH_EXT: begin
          // bits shifted out of the 29-bit window make the length too large
          acc_next      = {acc[wsfd_pkg::LEN_W-9:0], byte_in};
          acc_ovf_next  = acc_ovf | (acc[wsfd_pkg::LEN_W-1:wsfd_pkg::LEN_W-8] != 8'd0);
          ext_left_next = ext_left - 4'd1;
          if (ext_left == 4'd1) begin
            fin     = 1'b1;
            fin_len = acc_next;
            fin_big = acc_ovf_next;
          end
        end
        PH_BODY: begin
          body_left_next = body_left - {{(wsfd_pkg::LEN_W-1){1'b0}}, 1'b1};
          res_valid      = 1'b1;
          res.kind       = wsfd_pkg::KIND_PAYLOAD;
          res.data       = byte_in;
          if (body_left == {{(wsfd_pkg::LEN_W-1){1'b0}}, 1'b1}) begin
            res.last   = 1'b1;
            phase_next = PH_HDR0;
          end
        end
        default: begin
          phase_next = PH_HDR0;
        end
      endcase

      if (fin) begin
        res_valid  = 1'b1;
        phase_next = PH_HDR0;
        if (fin_big || fin_len > max_len) begin
          res.kind = wsfd_pkg::KIND_ERROR;
          res.last = 1'b1;
          res.err  = wsfd_pkg::ERR_TOO_LARGE;
        end else if (fin_len == '0) begin
          res.last = 1'b1;
        end else begin
          res.len        = fin_len;
          body_left_next = fin_len;
          phase_next     = PH_BODY;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_HDR0;
      held_opcode <= 4'd0;
      held_first  <= 8'd0;
      acc         <= '0;
      acc_ovf     <= 1'b0;
      ext_left    <= 4'd0;
      body_left   <= '0;
      max_len     <= wsfd_pkg::LIMIT_RESET;
    end else begin
      phase       <= phase_next;
      held_opcode <= held_opcode_next;
      held_first  <= held_first_next;
      acc         <= acc_next;
      acc_ovf     <= acc_ovf_next;
      ext_left    <= ext_left_next;
      body_left   <= body_left_next;
      if (cfg_we) begin
        max_len <= cfg_data;
      end
    end
  end

endmodule

[hw/rtl/wsfd_out_fifo.sv]
module wsfd_out_fifo (
  input  logic              clk,
  input  logic              rst,
  input  logic              wr_en,
  input  wsfd_pkg::result_t wr_data,
  output logic              full,
  output logic              rd_valid,
  input  logic              rd_stall,
  output wsfd_pkg::result_t rd_data
);

  wsfd_pkg::result_t mem [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] count;
  logic       rd_en;

  assign full     = (count == 2'd2);
  assign rd_valid = (count != 2'd0);
  assign rd_en    = rd_valid && !rd_stall;
  assign rd_data  = mem[rptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (wr_en) begin
        wptr <= ~wptr;
      end
      if (rd_en) begin
        rptr <= ~rptr;
      end
      case ({wr_en, rd_en})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

[hw/rtl/websocket_frame_deframer_top.sv]
// WebSocket frame deframer: parses unmasked frames from a byte stream.
// Input channel: in_valid / in_stall with in_byte, one byte per item.
// Output channel: out_valid / out_stall with kind, frame_opcode,
//   payload_length, data_byte, last and error_code; at most one result per
//   input byte (header bytes before the length completes give none).
// Config: cfg_valid / cfg_ready with cfg_data writes max_payload_length;
//   cfg_ready is always high. Write only while the block is idle.
// Throughput: one byte per cycle while the output queue has room. Each byte goes through an input
//   register, then the parser logic, which updates its state and writes
//   any result into a two-entry output queue.
// Result path: a byte in the input register is parsed and its result written into
//   the output queue; out_valid is high while that queue holds a result.
// Reset (rst, synchronous): parser back to the first header byte, limit to
//   268435456, queue emptied.
// When the receiver stalls, results wait in the queue; once it is full the
//   input register holds its byte and in_stall rises until space frees up.
module websocket_frame_deframer_top (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [7:0]                  in_byte,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [1:0]                  kind,
  output logic [3:0]                  frame_opcode,
  output logic [wsfd_pkg::LEN_W-1:0]  payload_length,
  output logic [7:0]                  data_byte,
  output logic                        last,
  output logic                        error_code,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [wsfd_pkg::LEN_W-1:0]  cfg_data
);

  logic              iv;
  logic [7:0]        ibyte;
  logic              full;
  logic              step;
  logic              res_valid;
  wsfd_pkg::result_t res;
  wsfd_pkg::result_t head;

  assign step      = iv && !full;
  assign in_stall  = iv && full;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      iv <= 1'b0;
    end else if (in_valid && !in_stall) begin
      iv <= 1'b1;
    end else if (step) begin
      iv <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      ibyte <= in_byte;
    end
  end

  wsfd_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .byte_in   (ibyte),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data),
    .res_valid (res_valid),
    .res       (res)
  );

  wsfd_out_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (res_valid),
    .wr_data  (res),
    .full     (full),
    .rd_valid (out_valid),
    .rd_stall (out_stall),
    .rd_data  (head)
  );

  assign kind           = head.kind;
  assign frame_opcode   = head.opcode;
  assign payload_length = head.len;
  assign data_byte      = head.data;
  assign last           = head.last;
  assign error_code     = head.err;

endmodule

[hw/rtl/wsfd_checker.sv]
module wsfd_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic [1:0]                  kind,
  input logic [3:0]                  frame_opcode,
  input logic [wsfd_pkg::LEN_W-1:0]  payload_length,
  input logic [7:0]                  data_byte,
  input logic                        last,
  input logic                        error_code
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(kind) && $stable(payload_length)
      && $stable(data_byte) && $stable(last) && $stable(frame_opcode))
    else $error("stalled output item changed");

  a_error_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == wsfd_pkg::KIND_ERROR |-> last && payload_length == '0)
    else $error("error item not last or carries a length");

  a_len_only_start: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind != wsfd_pkg::KIND_START |-> payload_length == '0)
    else $error("length shown outside frame start");

  a_empty_frame: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == wsfd_pkg::KIND_START && last |-> payload_length == '0)
    else $error("frame start marked last with nonzero length");

  a_kind_err: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind != wsfd_pkg::KIND_ERROR |-> !error_code && kind != 2'd3)
    else $error("error code outside error item");

endmodule

bind websocket_frame_deframer_top wsfd_checker u_wsfd_checker (.*);

[tb/wsfd_result_checker.sv]
`timescale 1ns / 1ps

module wsfd_result_checker (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  input  logic                                 in_stall,
  input  logic [7:0]                           in_byte,
  input  logic                                 out_valid,
  input  logic                                 out_stall,
  input  logic [1:0]                           kind,
  input  logic [3:0]                           frame_opcode,
  input  logic [wsfd_pkg::LEN_W-1:0]           payload_length,
  input  logic [7:0]                           data_byte,
  input  logic                                 last,
  input  logic                                 error_code,
  input  logic                                 cfg_valid,
  input  logic                                 cfg_ready,
  input  logic [wsfd_pkg::LEN_W-1:0]           cfg_data,
  output int unsigned                          fail_count,
  output int unsigned                          pending
);

  localparam int unsigned MAX_PRINTS = 100;

  typedef enum logic [1:0] {HDR_FIRST, HDR_SECOND, EXT_LEN, BODY} parse_phase_t;

  parse_phase_t                 phase;
  logic [3:0]                   opcode_q;
  logic [7:0]                   first_byte_q;
  logic [63:0]                  len_acc;
  logic [3:0]                   ext_left;
  logic [wsfd_pkg::LEN_W-1:0]   body_left;
  logic [wsfd_pkg::LEN_W-1:0]   limit_q;
  wsfd_pkg::result_t            parsed_q[$];
  wsfd_pkg::result_t            want;
  wsfd_pkg::result_t            next_r;
  int unsigned                  mismatches = 0;

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= MAX_PRINTS) begin
      $display("%0t: mismatch: %s", $time, msg);
    end
  endtask

  // length is complete: too large, empty frame, or start of a body
  function automatic wsfd_pkg::result_t close_length(input logic [63:0] len);
    wsfd_pkg::result_t r;
    r = '0;
    r.opcode = opcode_q;
    r.last = 1'b1;
    phase = HDR_FIRST;
    if (len > {35'd0, limit_q}) begin
      r.kind = wsfd_pkg::KIND_ERROR;
      r.err  = wsfd_pkg::ERR_TOO_LARGE;
    end else if (len == 64'd0) begin
      r.kind = wsfd_pkg::KIND_START;
    end else begin
      r.kind    = wsfd_pkg::KIND_START;
      r.len     = len[wsfd_pkg::LEN_W-1:0];
      r.last    = 1'b0;
      body_left = len[wsfd_pkg::LEN_W-1:0];
      phase     = BODY;
    end
    return r;
  endfunction

  function automatic bit parse_byte(input logic [7:0] b, output wsfd_pkg::result_t r);
    logic [6:0] code;
    r = '0;
    r.opcode = opcode_q;
    code = b[6:0];
    case (phase)
      HDR_FIRST: begin
        first_byte_q = b;
        opcode_q     = b[3:0];
        phase        = HDR_SECOND;
        return 1'b0;
      end
      HDR_SECOND: begin
        // FIN clear or mask set: reject and resync on the next byte
        if (!first_byte_q[7] || b[7]) begin
          phase  = HDR_FIRST;
          r.kind = wsfd_pkg::KIND_ERROR;
          r.last = 1'b1;
          r.err  = wsfd_pkg::ERR_UNSUPPORTED;
          return 1'b1;
        end
        if (code == wsfd_pkg::LEN_CODE_16 || code == wsfd_pkg::LEN_CODE_64) begin
          len_acc  = '0;
          ext_left = (code == wsfd_pkg::LEN_CODE_16) ?
                     wsfd_pkg::EXT_BYTES_16 : wsfd_pkg::EXT_BYTES_64;
          phase    = EXT_LEN;
          return 1'b0;
        end
        r = close_length({57'd0, code});
        return 1'b1;
      end
      EXT_LEN: begin
        len_acc  = {len_acc[55:0], b};
        ext_left = ext_left - 4'd1;
        if (ext_left != 4'd0) return 1'b0;
        r = close_length(len_acc);
        return 1'b1;
      end
      default: begin
        body_left = body_left - {{(wsfd_pkg::LEN_W-1){1'b0}}, 1'b1};
        r.kind = wsfd_pkg::KIND_PAYLOAD;
        r.data = b;
        if (body_left == '0) begin
          r.last = 1'b1;
          phase  = HDR_FIRST;
        end
        return 1'b1;
      end
    endcase
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      phase        = HDR_FIRST;
      opcode_q     = '0;
      first_byte_q = '0;
      len_acc      = '0;
      ext_left     = '0;
      body_left    = '0;
      limit_q      = wsfd_pkg::LIMIT_RESET;
      parsed_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (parsed_q.size() == 0) begin
          report_mismatch($sformatf("result with none expected (kind %0d)", kind));
        end else begin
          want = parsed_q.pop_front();
          if (kind !== want.kind)
            report_mismatch($sformatf("kind %0d, expected %0d", kind, want.kind));
          if (frame_opcode !== want.opcode)
            report_mismatch($sformatf("frame_opcode %0h, expected %0h",
                                      frame_opcode, want.opcode));
          if (payload_length !== want.len)
            report_mismatch($sformatf("payload_length %0d, expected %0d",
                                      payload_length, want.len));
          if (data_byte !== want.data)
            report_mismatch($sformatf("data_byte %0h, expected %0h", data_byte, want.data));
          if (last !== want.last)
            report_mismatch($sformatf("last %0b, expected %0b", last, want.last));
          if (error_code !== want.err)
            report_mismatch($sformatf("error_code %0b, expected %0b", error_code, want.err));
        end
      end
      if (cfg_valid && cfg_ready) begin
        limit_q = cfg_data;
      end
      if (in_valid && !in_stall) begin
        if (parse_byte(in_byte, next_r)) parsed_q.insert(parsed_q.size(), next_r);
      end
    end
    pending    <= parsed_q.size();
    fail_count <= mismatches;
  end

endmodule

[tb/websocket_frame_deframer_top_tb.sv]
`timescale 1ns / 1ps

module websocket_frame_deframer_top_tb;

  localparam int unsigned LONG_HOLD = 300;
  localparam int unsigned SETTLE    = 6;
  localparam int unsigned DRAIN     = 10;

  typedef enum int {LEN_FORM_7, LEN_FORM_16, LEN_FORM_64} len_form_t;

  logic                       clk = 1'b0;
  logic                       rst;
  logic                       in_valid;
  logic                       in_stall;
  logic [7:0]                 in_byte;
  logic                       out_valid;
  logic                       out_stall;
  logic [1:0]                 kind;
  logic [3:0]                 frame_opcode;
  logic [wsfd_pkg::LEN_W-1:0] payload_length;
  logic [7:0]                 data_byte;
  logic                       last;
  logic                       error_code;
  logic                       cfg_valid;
  logic                       cfg_ready;
  logic [wsfd_pkg::LEN_W-1:0] cfg_data;

  int unsigned                fail_count;
  int unsigned                pending;
  int unsigned                sent_count = 0;
  logic [wsfd_pkg::LEN_W-1:0] cur_limit = wsfd_pkg::LIMIT_RESET;
  bit                         idle_on = 1'b1;
  bit                         hold_req = 1'b0;
  bit                         hold_done = 1'b0;

  websocket_frame_deframer_top dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_byte        (in_byte),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .kind           (kind),
    .frame_opcode   (frame_opcode),
    .payload_length (payload_length),
    .data_byte      (data_byte),
    .last           (last),
    .error_code     (error_code),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data)
  );

  wsfd_result_checker result_check (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_byte        (in_byte),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .kind           (kind),
    .frame_opcode   (frame_opcode),
    .payload_length (payload_length),
    .data_byte      (data_byte),
    .last           (last),
    .error_code     (error_code),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data),
    .fail_count     (fail_count),
    .pending        (pending)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // receiver: random stall bursts, plus one long hold-off on request
  initial begin
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        out_stall <= 1'b0;
      end else if (idle_on && !rst && $urandom_range(0, 7) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 14)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  task automatic send_byte(input logic [7:0] b);
    in_valid <= 1'b1;
    in_byte  <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent_count++;
    if (idle_on && $urandom_range(0, 9) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
  endtask

  // random byte that never looks like an extended length code, so noise
  // cannot open a huge body
  function automatic logic [7:0] noise_byte();
    logic [7:0] b;
    b = 8'($urandom);
    if (b[7:1] == 7'h3F) b[6] = 1'b0;
    return b;
  endfunction

  task automatic drive_frame(input logic [3:0] op, input logic [63:0] len,
                             input len_form_t form);
    logic [7:0] b0;
    b0 = 8'($urandom);
    b0[7] = 1'b1;
    b0[3:0] = op;
    send_byte(b0);
    case (form)
      LEN_FORM_7: begin
        send_byte({1'b0, len[6:0]});
      end
      LEN_FORM_16: begin
        send_byte({1'b0, wsfd_pkg::LEN_CODE_16});
        send_byte(len[15:8]);
        send_byte(len[7:0]);
      end
      default: begin
        send_byte({1'b0, wsfd_pkg::LEN_CODE_64});
        for (int i = 7; i >= 0; i--) send_byte(len[8*i +: 8]);
      end
    endcase
    // rejected frames get no body
    if (len <= {35'd0, cur_limit}) begin
      repeat (len) send_byte(8'($urandom));
    end
  endtask

  task automatic write_limit(input logic [wsfd_pkg::LEN_W-1:0] v);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    // header bytes give no result and may still be in the pipe
    repeat (SETTLE) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    cur_limit = v;
  endtask

  task automatic run_phase(input int unsigned budget);
    int unsigned stop_at;
    int unsigned pick;
    logic [63:0] len;
    len_form_t   form;
    logic [7:0]  b0;
    logic [7:0]  b1;
    stop_at = sent_count + budget;
    while (sent_count < stop_at) begin
      pick = $urandom_range(0, 19);
      if (pick < 15) begin
        pick = $urandom_range(0, 9);
        if (pick < 5) begin
          form = LEN_FORM_7;
          len  = 64'($urandom_range(0, 24));
        end else if (pick < 6) begin
          form = LEN_FORM_7;
          len  = 64'($urandom_range(100, 125));
        end else if (pick < 8) begin
          form = LEN_FORM_16;
          len  = 64'($urandom_range(0, 1) ? $urandom_range(0, 140) : $urandom_range(0, 65535));
        end else begin
          form = LEN_FORM_64;
          case ($urandom_range(0, 2))
            0:       len = {$urandom, $urandom};
            1:       len = 64'($urandom_range(0, 32'h1FFF_FFFF));
            default: len = 64'($urandom_range(0, 140));
          endcase
        end
        // keep accepted bodies short
        if (len <= {35'd0, cur_limit} && len > 64'd140) len = 64'($urandom_range(0, 125));
        drive_frame(4'($urandom), len, form);
      end else if (pick < 18) begin
        b0 = 8'($urandom);
        b1 = 8'($urandom);
        if ($urandom_range(0, 1)) begin
          b0[7] = 1'b0;
        end else begin
          b0[7] = 1'b1;
          b1[7] = 1'b1;
        end
        send_byte(b0);
        send_byte(b1);
        if ($urandom_range(0, 1)) repeat ($urandom_range(1, 4)) send_byte(noise_byte());
      end else begin
        repeat ($urandom_range(1, 6)) send_byte(noise_byte());
      end
    end
  endtask

  initial begin
    #20_000_000;
    $display("websocket_frame_deframer_top test failed");
    $finish;
  end

  initial begin
    rst       = 1'b1;
    in_valid  = 1'b0;
    in_byte   = '0;
    cfg_valid = 1'b0;
    cfg_data  = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed: plain frame, empty frame, FIN clear, masked, 16-bit form
    // at the top opcode, 64-bit form too large
    drive_frame(4'h1, 64'd3, LEN_FORM_7);
    drive_frame(4'h9, 64'd0, LEN_FORM_7);
    send_byte(8'h01);
    send_byte(8'h05);
    send_byte(8'h82);
    send_byte(8'hFF);
    drive_frame(4'hF, 64'd2, LEN_FORM_16);
    drive_frame(4'h0, 64'hFFFF_FFFF_FFFF_FFFF, LEN_FORM_64);

    run_phase(120);

    write_limit('0);
    run_phase(120);

    // limit boundary, then a long receiver hold-off to back up the input
    write_limit(29'd5);
    drive_frame(4'h2, 64'd5, LEN_FORM_7);
    drive_frame(4'h2, 64'd6, LEN_FORM_16);
    hold_req <= 1'b1;
    run_phase(150);

    write_limit(29'h1FFF_FFFF);
    idle_on <= 1'b0;
    run_phase(120);
    idle_on <= 1'b1;

    write_limit(wsfd_pkg::LIMIT_RESET);
    run_phase(120);

    write_limit(29'd130);
    run_phase(150);

    write_limit(29'($urandom_range(0, 300)));
    run_phase(120);

    write_limit(29'($urandom));
    idle_on <= 1'b0;
    run_phase(150);

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    if (fail_count == 0) begin
      $display("websocket_frame_deframer_top test passed");
    end else begin
      $display("websocket_frame_deframer_top test failed");
    end
    $finish;
  end

endmodule

[websocket_frame_deframer_top.f]
hw/rtl/wsfd_pkg.sv
hw/rtl/wsfd_parser.sv
hw/rtl/wsfd_out_fifo.sv
hw/rtl/websocket_frame_deframer_top.sv
hw/rtl/wsfd_checker.sv
tb/wsfd_result_checker.sv
tb/websocket_frame_deframer_top_tb.sv
